// ----- hdl/oerg_pkg.sv -----
// ----------------------------------------------------------------------------
// oerg_pkg: shared types and codes for the execution report generator
// Command and report kind codes, control state encoding.
// ----------------------------------------------------------------------------
`default_nettype none
package oerg_pkg;
  localparam logic [2:0] CMD_SUBMIT  = 3'd0;
  localparam logic [2:0] CMD_TRADE   = 3'd1;
  localparam logic [2:0] CMD_CANCEL  = 3'd2;
  localparam logic [2:0] CMD_REPLACE = 3'd3;
  localparam logic [2:0] CMD_REJECT  = 3'd4;

  localparam logic [2:0] EXEC_NEW      = 3'd0;
  localparam logic [2:0] EXEC_TRADE    = 3'd1;
  localparam logic [2:0] EXEC_CANCELED = 3'd2;
  localparam logic [2:0] EXEC_REPLACED = 3'd3;
  localparam logic [2:0] EXEC_REJECTED = 3'd4;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_CALC, ST_MUL, ST_DIV, ST_WRITE, ST_EMIT
  } state_t;
endpackage
`default_nettype wire

// ----- hdl/order_execution_report_generator.sv -----
// ----------------------------------------------------------------------------
// order_execution_report_generator: per-order execution report engine
// Order state in one RAM indexed by {symbol, slot}; reports per event.
// ----------------------------------------------------------------------------
// channel | dir | handshake             | payload
// in_     | in  | in_tvalid/in_tready   | tuser: command, tdata: symbol_index..reject_code
// out_    | out | out_tvalid/out_tready | tuser: exec_kind, tdata: report, tlast: last_of_run
// Steps: idle takes the beat; submit/reject then read, calc, write, emit; cancel/replace
//   read, calc, write, then wait in the divider for the average and emit; a trade runs
//   read, calc, mul, write, div, emit per filled order and read, calc per skipped one.
// Reset: a clearing pass walks all SYMBOL_COUNT*ORDER_SLOTS entries of the order
//   RAM; no beat is accepted until it ends.
// Stalls: one item at a time; out_tready low holds the report register and the
//   next report waits in its emit step; the first fill of a trade is held back
//   until the resting order is looked up, so tlast marks the final report.
// ----------------------------------------------------------------------------
`default_nettype none
module order_execution_report_generator
  import oerg_pkg::*;
#(
  parameter int SYMBOL_COUNT = 16,
  parameter int ORDER_SLOTS  = 256
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // symbol_index[3:0] order_slot[11:4] resting_slot[19:12] quantity[43:20]
  // price[75:44] reject_code[79:76]
  input  wire logic [79:0]  in_tdata,
  input  wire logic [2:0]   in_tuser,   // command[2:0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // report_symbol[3:0] sequence_number[35:4] report_order[43:36]
  // last_quantity[67:44] filled_quantity[99:68] leaves_quantity[131:100]
  // last_price[163:132] average_price[195:164] reason_out[199:196]
  output logic [199:0]      out_tdata,
  output logic [2:0]        out_tuser,  // exec_kind[2:0]
  output logic              out_tlast
);
  localparam int SW    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int DEPTH = SYMBOL_COUNT * ORDER_SLOTS;
  localparam int AW    = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
  localparam int EW    = 1 + 32 + 32 + 64;

  state_t state_r, state_nxt;
  logic [2:0]  cmd_r;
  logic [3:0]  sym_r, code_r;
  logic [7:0]  slot_r, rest_r;
  logic [23:0] qty_r;
  logic [31:0] px_r;
  logic        second_r, second_nxt;   // working on resting order of a trade
  logic [AW-1:0] clr_r;
  logic [31:0] seq_r [SYMBOL_COUNT];

  // entry fields: {valid, orig, cum, notional}
  logic          we;
  logic [AW-1:0] addr;
  logic [EW-1:0] wdata, rdata;
  logic [31:0]   orig_r, cum_r;
  logic [63:0]   notl_r, prod_r;
  logic          div_start, div_done;
  logic [31:0]   avg;
  logic [31:0]   avg_r;
  logic [7:0]    cur_slot;
  logic          out_v_r;
  logic          held_r;               // first trade report parked in out_d_r
  logic [199:0]  out_d_r;
  logic [2:0]    out_k_r;
  logic          out_l_r;
  logic          have_more;
  logic          skip;

  assign cur_slot = second_r ? rest_r : slot_r;
  logic slot_ok;
  assign slot_ok = {24'd0, cur_slot} < ORDER_SLOTS;
  assign skip    = !slot_ok || (cmd_r == CMD_TRADE && !rdata[EW-1]);

  always_comb begin
    if (state_r == ST_CLEAR) addr = clr_r;
    else addr = AW'(({24'd0, sym_r} * ORDER_SLOTS) + {24'd0, cur_slot});
  end

  oerg_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  oerg_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(notl_r), .divisor(cum_r), .done(div_done), .quotient(avg)
  );

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_k_r;
  assign out_tlast  = out_l_r;
  assign have_more  = cmd_r == CMD_TRADE && !second_r;

  logic sym_ok, cmd_ok;
  assign sym_ok = {28'd0, in_tdata[3:0]} < SYMBOL_COUNT;
  assign cmd_ok = in_tuser <= CMD_REJECT;

  // next state
  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: if (in_tvalid && in_tready && cmd_ok && sym_ok) begin
        state_nxt  = ST_READ;
        second_nxt = 1'b0;
      end
      ST_READ: state_nxt = ST_CALC;
      ST_CALC: begin
        if (skip) begin
          if (have_more) second_nxt = 1'b1;
          state_nxt = have_more ? ST_READ : ST_IDLE;
        end else if (cmd_r == CMD_TRADE) state_nxt = ST_MUL;
        else state_nxt = ST_WRITE;
      end
      ST_MUL: state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = (cmd_r == CMD_SUBMIT || cmd_r == CMD_REJECT) ? ST_EMIT : ST_DIV;
      ST_DIV: if (div_done) state_nxt = ST_EMIT;
      ST_EMIT: if (!out_v_r) begin
        if (have_more) begin
          second_nxt = 1'b1;
          state_nxt  = ST_READ;
        end else state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    we        = 1'b0;
    wdata     = {1'b1, orig_r, cum_r, notl_r};
    div_start = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
      end
      ST_WRITE: begin
        we        = cmd_r != CMD_REJECT && cmd_r != CMD_CANCEL;
        div_start = cmd_r != CMD_SUBMIT && cmd_r != CMD_REJECT;
      end
      default: ;
    endcase
  end

  logic [32:0] csum;
  logic [64:0] nsum;
  assign csum = {1'b0, rdata[95:64]} + {9'd0, qty_r};
  assign nsum = {1'b0, notl_r} + {1'b0, prod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      second_r <= 1'b0;
      out_v_r  <= 1'b0;
      held_r   <= 1'b0;
      for (int i = 0; i < SYMBOL_COUNT; i++) seq_r[i] <= '0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + AW'(1);
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      if (state_r == ST_EMIT && !out_v_r) begin
        // hold the first fill until the resting order is known
        if (have_more) held_r <= 1'b1;
        else out_v_r <= 1'b1;
        seq_r[sym_r[SW-1:0]] <= seq_r[sym_r[SW-1:0]] + 32'd1;
      end
      if (state_r == ST_CALC && held_r) begin
        held_r  <= 1'b0;
        out_v_r <= 1'b1;
      end
    end
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tuser;
      sym_r  <= in_tdata[3:0];
      slot_r <= in_tdata[11:4];
      rest_r <= in_tdata[19:12];
      qty_r  <= in_tdata[43:20];
      px_r   <= in_tdata[75:44];
      code_r <= in_tdata[79:76];
    end
    // resting order skipped: the parked report is the final one
    if (state_r == ST_CALC && held_r && skip) out_l_r <= 1'b1;
    if (state_r == ST_CALC) begin
      unique case (cmd_r)
        CMD_SUBMIT: begin
          orig_r <= {8'd0, qty_r};
          cum_r  <= '0;
          notl_r <= '0;
        end
        CMD_TRADE: begin
          orig_r <= rdata[127:96];
          cum_r  <= csum[32] ? 32'hFFFF_FFFF : csum[31:0];
          notl_r <= rdata[63:0];
        end
        CMD_REPLACE: begin
          logic [32:0] os;
          os = (rdata[EW-1] ? {1'b0, rdata[95:64]} : 33'd0) + {9'd0, qty_r};
          orig_r <= os[32] ? 32'hFFFF_FFFF : os[31:0];
          cum_r  <= rdata[EW-1] ? rdata[95:64] : 32'd0;
          notl_r <= rdata[EW-1] ? rdata[63:0] : 64'd0;
        end
        default: begin
          orig_r <= rdata[127:96];
          cum_r  <= rdata[EW-1] ? rdata[95:64] : 32'd0;
          notl_r <= rdata[EW-1] ? rdata[63:0] : 64'd0;
        end
      endcase
      prod_r <= {40'd0, qty_r} * {32'd0, px_r};
    end
    if (state_r == ST_MUL) notl_r <= nsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : nsum[63:0];
    if (state_r == ST_WRITE) avg_r <= '0;
    if (div_done) avg_r <= avg;
    if (state_r == ST_EMIT && !out_v_r) begin
      logic [2:0]  kind;
      logic [23:0] lq;
      logic [31:0] fq, lv, lp, ap;
      logic [3:0]  rs;
      kind = EXEC_REJECTED; lq = '0; fq = '0; lv = '0; lp = '0; ap = '0; rs = '0;
      unique case (cmd_r)
        CMD_SUBMIT: begin kind = EXEC_NEW; lv = orig_r; end
        CMD_TRADE: begin
          kind = EXEC_TRADE; lq = qty_r; fq = cum_r; lp = px_r; ap = avg_r;
          lv = orig_r > cum_r ? orig_r - cum_r : 32'd0;
        end
        CMD_CANCEL: begin kind = EXEC_CANCELED; fq = cum_r; ap = avg_r; end
        CMD_REPLACE: begin
          kind = EXEC_REPLACED; fq = cum_r; lv = {8'd0, qty_r}; lp = px_r; ap = avg_r;
        end
        default: rs = code_r;
      endcase
      out_d_r <= {rs, ap, lp, lv, fq, lq, cur_slot, seq_r[sym_r[SW-1:0]], sym_r};
      out_k_r <= kind;
      out_l_r <= !have_more;
    end
  end

  // a report register is never overwritten while still pending
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("report dropped under stall");
  // input is only taken with the sequencer idle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> state_r == ST_IDLE)
    else $error("input accepted while busy");
  // the divider is only started in the write step that follows calc or mul
  assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> $past(state_r) == ST_MUL || $past(state_r) == ST_CALC)
    else $error("divider started out of sequence");
endmodule
`default_nettype wire

// ----- hdl/oerg_ram.sv -----
// ----------------------------------------------------------------------------
// oerg_ram: generic single-port synchronous RAM
// One access per cycle (a write also reads the old data), registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module oerg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- hdl/oerg_div.sv -----
// ----------------------------------------------------------------------------
// oerg_div: 64-by-32 restoring divider, one quotient bit per cycle
// Quotient saturates to 32 bits; a zero divisor yields zero.
// ----------------------------------------------------------------------------
`default_nettype none
module oerg_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [63:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[31:0], quo_r[63]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done     = busy_r && cnt_r == 7'd1;
  // saturate on the final shift
  always_comb begin
    logic [63:0] q;
    q = trial >= {1'b0, dvs_r} ? {quo_r[62:0], 1'b1} : {quo_r[62:0], 1'b0};
    quotient = (dvs_r == '0) ? 32'd0 : ((|q[63:32]) ? 32'hFFFF_FFFF : q[31:0]);
  end
endmodule
`default_nettype wire
